// ----- design/bfsp_pkg.sv -----
// Package with constants and types shared by the frame sync parser modules.
package bfsp_pkg;
  localparam int MaxPayload = 128;
  localparam int BufSize    = MaxPayload + 8;
  localparam int AddrW      = $clog2(BufSize);
  localparam logic [7:0] SyncA = 8'hb5;
  localparam logic [7:0] SyncB = 8'h62;

  localparam logic [2:0] StWait = 3'd0;
  localparam logic [2:0] StSync = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StCk   = 3'd3;
  localparam logic [2:0] StOk   = 3'd4;
  localparam logic [2:0] StRead = 3'd5;

  typedef struct packed {
    logic [6:0]  read_index;
    logic [7:0]  data_byte;
    logic        mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  buffer_fill;
    logic [31:0] frame_count;
    logic [31:0] drop_count;
    logic [31:0] byte_count;
    logic [7:0]  read_data;
    logic [7:0]  payload_length;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
    logic [2:0]  status;
  } out_item_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpStart,     // latch the input item, count the push
    OpFullDrop,  // drop the oldest byte
    OpWrite,     // write the new byte and grow the window
    OpRdAddr,    // issue a window read at the offset register
    OpLatchA,    // keep the read byte as the first sync, low length or class byte
    OpLatchB,    // keep the read byte as the second byte
    OpCkInit,    // clear sums, offset to 2, keep the frame length
    OpCkStep,    // accumulate read byte, advance offset
    OpDrop,      // drop the oldest byte
    OpAccept,    // take the frame
    OpRead,      // latch read data
    OpSetOff     // load the offset register
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] off;
    logic [2:0] status;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic       mode;
    logic       full;
    logic [7:0] fill;
    logic [7:0] last_len;
    logic [6:0] read_index;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] rdata;
    logic [8:0] len;
    logic [7:0] off;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic       out_busy;
  } stat_t;
endpackage

// ----- design/bfsp_stream_if.sv -----
// Valid/ready channel carrying one item of a given type.
interface bfsp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/binary_frame_sync_parser.sv -----
// Top level of the binary frame sync parser.
// One result per input transfer; a new transfer is accepted only once the
// controller is idle again after emitting the previous result. A push writes
// its byte to the window, then checks the two sync bytes, the two length bytes,
// the length against the maximum payload and the fill against the frame size,
// and finally the checksum, which is walked over the single-port frame store
// alternately addressing and accumulating one byte at a time. The frame store
// holds no reset state and needs no clearing pass; results wait in an output
// register until taken, and a new result waits while the last is untaken.
module binary_frame_sync_parser (
  input  logic clk_i,
  input  logic rst_ni,
  bfsp_stream_if.sink   in_i,
  bfsp_stream_if.source out_o
);
  bfsp_pkg::cmd_t  cmd;
  bfsp_pkg::stat_t stat;

  bfsp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  bfsp_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .item_i(in_i.data), .stat_o(stat),
    .out_ready_i(out_o.ready), .out_valid_o(out_o.valid), .out_data_o(out_o.data)
  );
endmodule

// ----- design/bfsp_ram.sv -----
// Generic single-port RAM with registered read.
module bfsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/bfsp_datapath.sv -----
// Datapath: window pointers, counters, checksum sums, frame store and output register.
module bfsp_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bfsp_pkg::cmd_t          cmd_i,
  input  bfsp_pkg::in_item_t      item_i,
  output bfsp_pkg::stat_t         stat_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output bfsp_pkg::out_item_t     out_data_o
);
  localparam int AW = bfsp_pkg::AddrW;
  localparam logic [8:0] Size9 = 9'(bfsp_pkg::BufSize);

  logic [7:0]  start_q, fill_q, cls_q, id_q, len_last_q;
  logic [31:0] bytes_q, drops_q, frames_q;
  logic [7:0]  dbyte_q, a_q, b_q, cka_q, ckb_q, off_q;
  logic [7:0]  len_q;
  logic [6:0]  ridx_q;
  logic        mode_q, ov_q;
  bfsp_pkg::out_item_t out_q;
  logic [7:0]  ram_rdata;
  logic        we;
  logic [AW-1:0] addr;

  // Ring address of a window offset; offsets stay below the buffer size.
  function automatic logic [AW-1:0] wrap(input logic [7:0] s, input logic [7:0] o);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, o};
    if (t >= Size9) t = t - Size9;
    return t[AW-1:0];
  endfunction

  always_comb begin
    we = (cmd_i.op == bfsp_pkg::OpWrite);
    addr = we ? wrap(start_q, fill_q) : wrap(start_q, off_q);
  end

  bfsp_ram #(.Width(8), .Depth(bfsp_pkg::BufSize)) u_store (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(dbyte_q), .rdata_o(ram_rdata)
  );

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0; fill_q <= '0; cls_q <= '0; id_q <= '0; len_last_q <= '0;
      bytes_q <= '0; drops_q <= '0; frames_q <= '0; ov_q <= 1'b0;
      off_q <= '0;
    end else begin
      case (cmd_i.op)
        bfsp_pkg::OpStart: if (!item_i.mode) bytes_q <= bytes_q + 32'd1;
        bfsp_pkg::OpFullDrop, bfsp_pkg::OpDrop: begin
          drops_q <= drops_q + 32'd1;
          if (fill_q != 8'd0) begin
            fill_q  <= fill_q - 8'd1;
            start_q <= 8'(wrap(start_q, 8'd1));
          end
        end
        bfsp_pkg::OpWrite:  fill_q <= fill_q + 8'd1;
        bfsp_pkg::OpSetOff: off_q <= cmd_i.off;
        bfsp_pkg::OpCkInit: off_q <= 8'd2;
        bfsp_pkg::OpCkStep: off_q <= off_q + 8'd1;
        bfsp_pkg::OpAccept: begin
          frames_q   <= frames_q + 32'd1;
          cls_q      <= a_q;
          id_q       <= b_q;
          len_last_q <= len_q;
          start_q    <= 8'(wrap(start_q, 8'd6));
          fill_q     <= '0;
        end
        default: ;
      endcase
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Payload registers. The frame length is kept at the start of the checksum
  // walk, since the class and id later reuse the byte registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bfsp_pkg::OpStart: begin
        dbyte_q <= item_i.data_byte; ridx_q <= item_i.read_index;
        mode_q <= item_i.mode;
      end
      bfsp_pkg::OpLatchA: a_q <= ram_rdata;
      bfsp_pkg::OpLatchB: b_q <= ram_rdata;
      bfsp_pkg::OpCkInit: begin
        cka_q <= '0; ckb_q <= '0;
        len_q <= stat_o.len[7:0];
      end
      bfsp_pkg::OpCkStep: begin
        cka_q <= cka_q + ram_rdata;
        ckb_q <= ckb_q + cka_q + ram_rdata;
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_q.status <= cmd_i.status;
      out_q.msg_class <= (cmd_i.op == bfsp_pkg::OpAccept) ? a_q : cls_q;
      out_q.msg_id <= (cmd_i.op == bfsp_pkg::OpAccept) ? b_q : id_q;
      out_q.payload_length <= (cmd_i.op == bfsp_pkg::OpAccept) ? len_q : len_last_q;
      out_q.read_data <= (cmd_i.op == bfsp_pkg::OpRead) ? ram_rdata : 8'd0;
      out_q.byte_count <= bytes_q;
      out_q.drop_count <= (cmd_i.op == bfsp_pkg::OpDrop) ? drops_q + 32'd1 : drops_q;
      out_q.frame_count <= (cmd_i.op == bfsp_pkg::OpAccept) ? frames_q + 32'd1 : frames_q;
      out_q.buffer_fill <= (cmd_i.op == bfsp_pkg::OpAccept) ? 8'd0 :
                           (cmd_i.op == bfsp_pkg::OpDrop && fill_q != 8'd0) ? fill_q - 8'd1 :
                           fill_q;
    end
  end

  // Length of the frame in the window, from the low and high length bytes.
  logic [15:0] len16;
  assign len16 = {b_q, a_q};

  always_comb begin
    stat_o = '0;
    stat_o.mode = mode_q;
    stat_o.full = (fill_q >= 8'(bfsp_pkg::BufSize));
    stat_o.fill = fill_q;
    stat_o.last_len = len_last_q;
    stat_o.read_index = ridx_q;
    stat_o.byte_a = a_q;
    stat_o.byte_b = b_q;
    stat_o.rdata = ram_rdata;
    stat_o.len = (len16 > 16'(bfsp_pkg::MaxPayload)) ? 9'h1ff : len16[8:0];
    stat_o.off = off_q;
    stat_o.ck_a = cka_q;
    stat_o.ck_b = ckb_q;
    stat_o.out_busy = ov_q & ~out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  ap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 8'(bfsp_pkg::BufSize)) else $error("fill above buffer size");
  ap_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q < 8'(bfsp_pkg::BufSize)) else $error("window start out of range");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result lost");
`endif
endmodule

// ----- design/bfsp_ctrl.sv -----
// Controller sequencing one item through the datapath.
module bfsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfsp_pkg::stat_t    stat_i,
  output bfsp_pkg::cmd_t     cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_WRITE, S_CHK, S_RD0, S_RD0W, S_RD1, S_RD1W, S_CMPS,
    S_RL0, S_RL0W, S_RL1, S_RL1W, S_CMPL, S_CKI, S_CKR, S_CKW, S_CKE, S_CKEW,
    S_CKF, S_CKFW, S_CKC, S_RDR, S_RDW, S_EMIT, S_CLO, S_CLOW, S_CLOC
  } state_e;

  state_e state_q;
  logic [2:0] status_q;
  logic [7:0] exp_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; status_q <= bfsp_pkg::StWait; exp_a_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DISPATCH;
        S_DISPATCH: begin
          if (stat_i.mode) state_q <= S_RDR;
          else state_q <= S_WRITE;
        end
        S_WRITE: state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.fill < 8'd2) begin status_q <= bfsp_pkg::StWait; state_q <= S_EMIT; end
          else state_q <= S_RD0;
        end
        S_RD0: state_q <= S_RD0W;
        S_RD0W: state_q <= S_RD1;
        S_RD1: state_q <= S_RD1W;
        S_RD1W: state_q <= S_CMPS;
        S_CMPS: begin
          if (stat_i.byte_a != bfsp_pkg::SyncA || stat_i.byte_b != bfsp_pkg::SyncB) begin
            status_q <= bfsp_pkg::StSync; state_q <= S_EMIT;
          end else if (stat_i.fill < 8'd6) begin
            status_q <= bfsp_pkg::StWait; state_q <= S_EMIT;
          end else state_q <= S_RL0;
        end
        S_RL0: state_q <= S_RL0W;
        S_RL0W: state_q <= S_RL1;
        S_RL1: state_q <= S_RL1W;
        S_RL1W: state_q <= S_CMPL;
        S_CMPL: begin
          if (stat_i.len == 9'h1ff) begin status_q <= bfsp_pkg::StLen; state_q <= S_EMIT; end
          else if ({1'b0, stat_i.fill} < stat_i.len + 9'd8) begin
            status_q <= bfsp_pkg::StWait; state_q <= S_EMIT;
          end else state_q <= S_CKI;
        end
        S_CKI: state_q <= S_CKR;
        S_CKR: state_q <= S_CKW;
        S_CKW: begin
          if ({1'b0, stat_i.off} + 9'd1 == stat_i.len + 9'd6) state_q <= S_CKE;
          else state_q <= S_CKR;
        end
        S_CKE: state_q <= S_CKEW;
        S_CKEW: state_q <= S_CKF;
        S_CKF: begin exp_a_q <= stat_i.rdata; state_q <= S_CKFW; end
        S_CKFW: state_q <= S_CKC;
        S_CKC: begin
          if (exp_a_q != stat_i.ck_a || stat_i.rdata != stat_i.ck_b) begin
            status_q <= bfsp_pkg::StCk; state_q <= S_EMIT;
          end else state_q <= S_CLO;
        end
        S_CLO: state_q <= S_CLOW;
        S_CLOW: state_q <= S_CLOC;
        S_CLOC: begin status_q <= bfsp_pkg::StOk; state_q <= S_EMIT; end
        S_RDR: state_q <= S_RDW;
        S_RDW: begin status_q <= bfsp_pkg::StRead; state_q <= S_EMIT; end
        S_EMIT: if (!stat_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Command decode per state. An offset loaded in one state addresses the
  // store in the next, and its byte arrives one state later.
  always_comb begin
    cmd_o = '0;
    cmd_o.op = bfsp_pkg::OpNone;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: if (in_valid_i) cmd_o.op = bfsp_pkg::OpStart;
      S_DISPATCH: begin
        if (stat_i.mode) begin
          cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = {1'b0, stat_i.read_index};
        end else if (stat_i.full) cmd_o.op = bfsp_pkg::OpFullDrop;
      end
      S_WRITE: cmd_o.op = bfsp_pkg::OpWrite;
      S_CHK: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd0; end
      S_RD0: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd1; end
      S_RD0W: cmd_o.op = bfsp_pkg::OpLatchA;
      S_RD1W: cmd_o.op = bfsp_pkg::OpLatchB;
      S_CMPS: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd4; end
      S_RL0: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd5; end
      S_RL0W: cmd_o.op = bfsp_pkg::OpLatchA;
      S_RL1W: cmd_o.op = bfsp_pkg::OpLatchB;
      S_CKI: cmd_o.op = bfsp_pkg::OpCkInit;
      S_CKW: cmd_o.op = bfsp_pkg::OpCkStep;
      S_CKE: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'(stat_i.len + 9'd6); end
      S_CKEW: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'(stat_i.len + 9'd7); end
      S_CKC: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd2; end
      S_CLO: begin cmd_o.op = bfsp_pkg::OpSetOff; cmd_o.off = 8'd3; end
      S_CLOW: cmd_o.op = bfsp_pkg::OpLatchA;
      S_CLOC: cmd_o.op = bfsp_pkg::OpLatchB;
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          case (status_q)
            bfsp_pkg::StSync, bfsp_pkg::StLen, bfsp_pkg::StCk: cmd_o.op = bfsp_pkg::OpDrop;
            bfsp_pkg::StOk:   cmd_o.op = bfsp_pkg::OpAccept;
            bfsp_pkg::StRead: begin
              if (stat_i.read_index < stat_i.last_len[6:0] || stat_i.last_len[7])
                cmd_o.op = bfsp_pkg::OpRead;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef NO_ASSERTIONS
  ap_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE) else $error("emit not followed by idle");
  ap_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISPATCH) else $error("transfer not started");
  ap_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.emit) else $error("emit while idle");
`endif
endmodule
